// ===== rtl/fcd_pkg.sv =====
// Shared types, constants and helper functions of the FCM/DFCM value compressor.
package fcd_pkg;

    localparam int VALUE_W     = 64;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;
    localparam int PEND_W      = QCNT_W + 1;

    // Hash shifts and the bit positions that feed the hashes.
    localparam int CTX_SHIFT = 6;
    localparam int CTX_TAKE  = 48;
    localparam int DLT_SHIFT = 2;
    localparam int DLT_TAKE  = 40;

    localparam logic [3:0] DFCM_FLAG  = 4'h8;
    localparam logic [3:0] PAD_NIBBLE = 4'h7;

    // One encoded value on its way from the front end to the byte packer.
    typedef struct packed {
        logic [3:0]         nib;
        logic [VALUE_W-1:0] res;
        logic               fin;
    } fcd_item_t;

    typedef struct packed {
        logic clearing;
        logic s1_valid;
        logic s2_valid;
    } fcd_front_stat_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_HEAD,
        BK_RES_A,
        BK_RES_B
    } back_state_t;

    function automatic logic [3:0] zero_bytes(input logic [VALUE_W-1:0] x);
        logic [3:0] n;
        logic       hit;
        n   = 4'd0;
        hit = 1'b0;
        for (int i = 7; i >= 0; i--)
        begin
            if (!hit)
            begin
                if (x[8*i +: 8] == 8'h00)
                    n = n + 4'd1;
                else
                    hit = 1'b1;
            end
        end
        return n;
    endfunction

    function automatic logic [2:0] zero_bits8(input logic [7:0] b);
        logic [2:0] n;
        logic       hit;
        n   = 3'd0;
        hit = 1'b0;
        for (int i = 7; i >= 0; i--)
        begin
            if (!hit)
            begin
                if (!b[i])
                    n = n + 3'd1;
                else
                    hit = 1'b1;
            end
        end
        return n;
    endfunction

    // Leading zero bits, 0 to 64: first the zero bytes, then the bits of the top nonzero byte.
    function automatic logic [6:0] lead_zeros(input logic [VALUE_W-1:0] x);
        logic [3:0] zb;
        logic [2:0] pos;
        logic [7:0] b;
        zb  = zero_bytes(x);
        pos = 3'd7 - zb[2:0];
        b   = x[{pos, 3'b000} +: 8];
        if (zb[3])
            return 7'd64;
        return {1'b0, zb[2:0], 3'b000} + {4'b0000, zero_bits8(b)};
    endfunction

    function automatic logic [3:0] byte_count(input logic [3:0] nib);
        logic [2:0] c;
        c = nib[2:0];
        if (c > 3'd3)
            return 4'd7 - {1'b0, c};
        return 4'd8 - {1'b0, c};
    endfunction

endpackage

// ===== rtl/fcd_in_if.sv =====
// Input channel: one 64-bit value and its end-of-stream mark per request.
interface fcd_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic        final_value;

    modport source (output valid, output value, output final_value, input ready);
    modport sink   (input valid, input value, input final_value, output ready);
endinterface

// ===== rtl/fcd_out_if.sv =====
// Output channel: one compressed byte and its end marks per request.
interface fcd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_end;
    logic       stream_end;

    modport source (output valid, output out_byte, output run_end, output stream_end,
                    input ready);
    modport sink   (input valid, input out_byte, input run_end, input stream_end,
                    output ready);
endinterface

// ===== rtl/fcd_front.sv =====
// Front end: prediction tables, hashing, predictor choice and leading-zero coding.
module fcd_front #(
    parameter int TABLE_ENTRIES = 1024
) (
    input  logic                     clk,
    input  logic                     rst_n,
    fcd_in_if.sink                   in_ch,
    input  logic [fcd_pkg::QCNT_W-1:0] q_count,
    output logic                     push,
    output fcd_pkg::fcd_item_t       push_item,
    output fcd_pkg::fcd_front_stat_t stat
);
    import fcd_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    logic [VALUE_W-1:0] ctx_mem [TABLE_ENTRIES];
    logic [VALUE_W-1:0] dlt_mem [TABLE_ENTRIES];
    logic [VALUE_W-1:0] ctx_rd_reg;
    logic [VALUE_W-1:0] dlt_rd_reg;

    logic [IDX_W-1:0]   ctx_idx_reg, ctx_idx_next;
    logic [IDX_W-1:0]   dlt_idx_reg, dlt_idx_next;
    logic [VALUE_W-1:0] prev_reg;
    logic               clr_busy_reg;
    logic [IDX_W-1:0]   clr_addr_reg;

    logic               s1_valid_reg;
    logic [VALUE_W-1:0] s1_value_reg;
    logic [VALUE_W-1:0] s1_prev_reg;
    logic               s1_fin_reg;

    logic               s2_valid_reg;
    logic [VALUE_W-1:0] s2_xf_reg;
    logic [VALUE_W-1:0] s2_xd_reg;
    logic               s2_fin_reg;

    logic               accept;
    logic [PEND_W-1:0]  pending;
    logic [VALUE_W-1:0] delta;
    logic [VALUE_W-1:0] ctx_hash;
    logic [VALUE_W-1:0] dlt_hash;
    logic               mem_we;
    logic [IDX_W-1:0]   ctx_wa;
    logic [IDX_W-1:0]   dlt_wa;
    logic [VALUE_W-1:0] ctx_wd;
    logic [VALUE_W-1:0] dlt_wd;
    logic [VALUE_W-1:0] dp;
    logic [6:0]         lz_f;
    logic [6:0]         lz_d;
    logic               use_fcm;
    logic [3:0]         zb;
    logic [2:0]         code;

    // Everything in flight is guaranteed a queue slot, so the two stages never stall.
    assign pending = PEND_W'(q_count) + PEND_W'(s1_valid_reg) + PEND_W'(s2_valid_reg);
    assign in_ch.ready = !clr_busy_reg && (pending < PEND_W'(QUEUE_DEPTH));
    assign accept = in_ch.valid && in_ch.ready;

    assign delta        = in_ch.value - prev_reg;
    assign ctx_hash     = (VALUE_W'(ctx_idx_reg) << CTX_SHIFT) ^ (in_ch.value >> CTX_TAKE);
    assign dlt_hash     = (VALUE_W'(dlt_idx_reg) << DLT_SHIFT) ^ (delta >> DLT_TAKE);
    assign ctx_idx_next = ctx_hash[IDX_W-1:0];
    assign dlt_idx_next = dlt_hash[IDX_W-1:0];

    // A value reads and overwrites the same entry in the same cycle; the read sees the old data.
    assign mem_we = clr_busy_reg || accept;
    assign ctx_wa = clr_busy_reg ? clr_addr_reg : ctx_idx_reg;
    assign dlt_wa = clr_busy_reg ? clr_addr_reg : dlt_idx_reg;
    assign ctx_wd = clr_busy_reg ? '0 : in_ch.value;
    assign dlt_wd = clr_busy_reg ? '0 : delta;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            ctx_mem[ctx_wa] <= ctx_wd;
        ctx_rd_reg <= ctx_mem[ctx_idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            dlt_mem[dlt_wa] <= dlt_wd;
        dlt_rd_reg <= dlt_mem[dlt_idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx_idx_reg  <= '0;
            dlt_idx_reg  <= '0;
            prev_reg     <= '0;
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + IDX_W'(1);
                if (clr_addr_reg == IDX_W'(TABLE_ENTRIES - 1))
                    clr_busy_reg <= 1'b0;
            end
            if (accept)
            begin
                ctx_idx_reg <= ctx_idx_next;
                dlt_idx_reg <= dlt_idx_next;
                prev_reg    <= in_ch.value;
            end
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    assign dp = dlt_rd_reg + s1_prev_reg;

    always_ff @(posedge clk)
    begin
        s1_value_reg <= in_ch.value;
        s1_prev_reg  <= prev_reg;
        s1_fin_reg   <= in_ch.final_value;
        s2_xf_reg    <= s1_value_reg ^ ctx_rd_reg;
        s2_xd_reg    <= s1_value_reg ^ dp;
        s2_fin_reg   <= s1_fin_reg;
    end

    // The context prediction wins ties.
    assign lz_f    = lead_zeros(s2_xf_reg);
    assign lz_d    = lead_zeros(s2_xd_reg);
    assign use_fcm = lz_f >= lz_d;
    assign zb      = use_fcm ? lz_f[6:3] : lz_d[6:3];
    assign code    = (zb >= 4'd4) ? 3'(zb - 4'd1) : zb[2:0];

    assign push          = s2_valid_reg;
    assign push_item.nib = (use_fcm ? 4'h0 : DFCM_FLAG) | {1'b0, code};
    assign push_item.res = use_fcm ? s2_xf_reg : s2_xd_reg;
    assign push_item.fin = s2_fin_reg;

    assign stat.clearing = clr_busy_reg;
    assign stat.s1_valid = s1_valid_reg;
    assign stat.s2_valid = s2_valid_reg;

endmodule

// ===== rtl/fcd_queue.sv =====
// Short queue of encoded values between the front end and the byte packer.
module fcd_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  fcd_pkg::fcd_item_t         push_item,
    input  logic                       pop,
    output fcd_pkg::fcd_item_t         head_item,
    output logic [fcd_pkg::QCNT_W-1:0] count
);
    import fcd_pkg::*;

    fcd_item_t         slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + QCNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

    assign head_item = slot_reg[rd_ptr_reg];
    assign count     = count_reg;

endmodule

// ===== rtl/fcd_back.sv =====
// Byte packer: pairs encoded values and sends header and residual bytes.
module fcd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  fcd_pkg::fcd_item_t q_item,
    output logic               q_pop,
    fcd_out_if.source          out_ch
);
    import fcd_pkg::*;

    back_state_t        state_reg, state_next;
    logic               held_reg, held_next;
    logic [3:0]         held_nib_reg, held_nib_next;
    logic [VALUE_W-1:0] held_res_reg, held_res_next;
    logic [7:0]         head_reg, head_next;
    logic [VALUE_W-1:0] res_a_reg, res_a_next;
    logic [3:0]         cnt_a_reg, cnt_a_next;
    logic [VALUE_W-1:0] res_b_reg, res_b_next;
    logic [3:0]         cnt_b_reg, cnt_b_next;
    logic               fin_reg, fin_next;

    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_byte_reg, out_byte_next;
    logic               run_end_reg, run_end_next;
    logic               stream_end_reg, stream_end_next;

    logic               slot_free;
    logic               emit;
    logic [7:0]         emit_byte;
    logic               emit_last;
    logic               load_ok;
    logic               completes;

    assign slot_free = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        state_next    = state_reg;
        held_next     = held_reg;
        held_nib_next = held_nib_reg;
        held_res_next = held_res_reg;
        head_next     = head_reg;
        res_a_next    = res_a_reg;
        cnt_a_next    = cnt_a_reg;
        res_b_next    = res_b_reg;
        cnt_b_next    = cnt_b_reg;
        fin_next      = fin_reg;
        emit          = 1'b0;
        emit_byte     = head_reg;
        emit_last     = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
            end
            BK_HEAD:
            begin
                if (slot_free)
                begin
                    emit      = 1'b1;
                    emit_byte = head_reg;
                    emit_last = (cnt_a_reg == 4'd0) && (cnt_b_reg == 4'd0);
                    if (cnt_a_reg != 4'd0)
                        state_next = BK_RES_A;
                    else if (cnt_b_reg != 4'd0)
                        state_next = BK_RES_B;
                    else
                        state_next = BK_IDLE;
                end
            end
            BK_RES_A:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    emit_byte  = res_a_reg[7:0];
                    emit_last  = (cnt_a_reg == 4'd1) && (cnt_b_reg == 4'd0);
                    res_a_next = res_a_reg >> 8;
                    cnt_a_next = cnt_a_reg - 4'd1;
                    if (cnt_a_reg == 4'd1)
                        state_next = (cnt_b_reg != 4'd0) ? BK_RES_B : BK_IDLE;
                end
            end
            BK_RES_B:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    emit_byte  = res_b_reg[7:0];
                    emit_last  = (cnt_b_reg == 4'd1);
                    res_b_next = res_b_reg >> 8;
                    cnt_b_next = cnt_b_reg - 4'd1;
                    if (cnt_b_reg == 4'd1)
                        state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        // The next value is taken while idle, or in the cycle that sends the last byte of a group.
        load_ok   = (state_reg == BK_IDLE) || (emit && emit_last);
        q_pop     = load_ok && q_valid;
        completes = held_reg || q_item.fin;

        if (q_pop)
        begin
            if (!completes)
            begin
                held_next     = 1'b1;
                held_nib_next = q_item.nib;
                held_res_next = q_item.res;
            end
            else
            begin
                if (held_reg)
                begin
                    head_next  = {held_nib_reg, q_item.nib};
                    res_a_next = held_res_reg;
                    cnt_a_next = byte_count(held_nib_reg);
                    res_b_next = q_item.res;
                    cnt_b_next = byte_count(q_item.nib);
                end
                else
                begin
                    // A lone final value is padded with an empty second half.
                    head_next  = {q_item.nib, PAD_NIBBLE};
                    res_a_next = q_item.res;
                    cnt_a_next = byte_count(q_item.nib);
                    res_b_next = '0;
                    cnt_b_next = 4'd0;
                end
                held_next  = 1'b0;
                fin_next   = q_item.fin;
                state_next = BK_HEAD;
            end
        end

        out_valid_next  = out_valid_reg;
        out_byte_next   = out_byte_reg;
        run_end_next    = run_end_reg;
        stream_end_next = stream_end_reg;
        if (emit)
        begin
            out_valid_next  = 1'b1;
            out_byte_next   = emit_byte;
            run_end_next    = emit_last;
            stream_end_next = emit_last && fin_reg;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            held_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_nib_reg   <= held_nib_next;
        held_res_reg   <= held_res_next;
        head_reg       <= head_next;
        res_a_reg      <= res_a_next;
        cnt_a_reg      <= cnt_a_next;
        res_b_reg      <= res_b_next;
        cnt_b_reg      <= cnt_b_next;
        fin_reg        <= fin_next;
        out_byte_reg   <= out_byte_next;
        run_end_reg    <= run_end_next;
        stream_end_reg <= stream_end_next;
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.out_byte   = out_byte_reg;
    assign out_ch.run_end    = run_end_reg;
    assign out_ch.stream_end = stream_end_reg;

endmodule

// ===== rtl/fcm_dfcm_float_compressor.sv =====
// Top level of the FCM/DFCM double-precision value compressor.
// After reset the block zeroes all TABLE_ENTRIES entries (1024 by default) of both prediction
// tables and holds in_ch.ready low meanwhile. It then takes one 64-bit value per cycle as long
// as its four-entry queue has room; a value passes the s1 and s2 stages before it is queued.
// Values are coded in pairs: the first value of a pair sends nothing, the second sends a header
// byte followed by the residual bytes of both values, low byte first; a final value that opens
// a pair goes out alone with a padding nibble. Output is one byte wide; a pair sends a header
// byte plus up to eight residual bytes per value. run_end marks the last byte of each pair or
// lone final value, and stream_end the last byte of a stream.
module fcm_dfcm_float_compressor #(
    parameter int TABLE_ENTRIES = 1024
) (
    input  logic      clk,
    input  logic      rst_n,
    fcd_in_if.sink    in_ch,
    fcd_out_if.source out_ch
);
    import fcd_pkg::*;

    logic              q_push;
    fcd_item_t         q_push_item;
    logic              q_pop;
    fcd_item_t         q_head;
    logic [QCNT_W-1:0] q_count;
    fcd_front_stat_t   front_stat;

    fcd_front #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .q_count   (q_count),
        .push      (q_push),
        .push_item (q_push_item),
        .stat      (front_stat)
    );

    fcd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .pop       (q_pop),
        .head_item (q_head),
        .count     (q_count)
    );

    fcd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_count != '0),
        .q_item  (q_head),
        .q_pop   (q_pop),
        .out_ch  (out_ch)
    );

    // No request is taken while the tables are being cleared.
    a_no_accept_while_clearing : assert property (
        @(posedge clk) disable iff (!rst_n)
        front_stat.clearing |-> !in_ch.ready
    ) else $error("input taken during table clearing");

    // The credit check in the front end must keep the queue from overflowing.
    a_queue_no_overflow : assert property (
        @(posedge clk) disable iff (!rst_n)
        q_push |-> (q_count < QCNT_W'(QUEUE_DEPTH)) || q_pop
    ) else $error("queue overflow");

    a_queue_no_underflow : assert property (
        @(posedge clk) disable iff (!rst_n)
        q_pop |-> q_count != '0
    ) else $error("queue underflow");

    // Every queued or in-flight value was once accepted, so the pipeline stays within its credit.
    a_credit_bound : assert property (
        @(posedge clk) disable iff (!rst_n)
        (PEND_W'(q_count) + PEND_W'(front_stat.s1_valid) + PEND_W'(front_stat.s2_valid))
            <= PEND_W'(QUEUE_DEPTH)
    ) else $error("in-flight values exceed queue space");

    a_stream_end_is_run_end : assert property (
        @(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.stream_end |-> out_ch.run_end
    ) else $error("stream end without run end");

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the FCM/DFCM value compressor: every output byte is predicted.
module testbench;
    import fcd_pkg::*;

    localparam int TB_ENTRIES   = 1024;
    localparam int RANDOM_ITEMS = 280;
    localparam int LONG_HOLD    = 300;

    typedef struct {
        logic [7:0] data;
        logic       run_end;
        logic       stream_end;
    } comp_byte_t;

    // Tracks both predictor tables and the pairing, and holds the bytes still to come.
    class compressed_stream_sb;
        logic [63:0] ctx_tab [TB_ENTRIES];
        logic [63:0] dlt_tab [TB_ENTRIES];
        logic [9:0]  ctx_idx;
        logic [9:0]  dlt_idx;
        logic [63:0] prev_word;
        logic        half_held;
        logic [3:0]  held_nib;
        logic [63:0] held_res;
        comp_byte_t  coming_bytes[$];
        int          mismatches;
        int          bytes_seen;

        function new();
            foreach (ctx_tab[i])
            begin
                ctx_tab[i] = '0;
                dlt_tab[i] = '0;
            end
            ctx_idx    = '0;
            dlt_idx    = '0;
            prev_word  = '0;
            half_held  = 1'b0;
            held_nib   = '0;
            held_res   = '0;
            mismatches = 0;
            bytes_seen = 0;
        endfunction

        function void report(string msg);
            $display("MISMATCH at byte %0d: %s", bytes_seen, msg);
            mismatches++;
        endfunction

        function int pending();
            return coming_bytes.size();
        endfunction

        function int top_zero_bits(logic [63:0] x);
            int n;
            n = 0;
            for (int i = 63; i >= 0 && !x[i]; i--)
                n++;
            return n;
        endfunction

        // Picks the closer prediction, returns the residual and its nibble, then trains.
        function logic [63:0] code_value(logic [63:0] v, output logic [3:0] nib);
            logic [63:0] fcm_guess;
            logic [63:0] dfcm_guess;
            logic [63:0] xf;
            logic [63:0] xd;
            logic [63:0] r;
            logic [63:0] d;
            logic        pick_fcm;
            int          zb;
            fcm_guess  = ctx_tab[ctx_idx];
            dfcm_guess = dlt_tab[dlt_idx] + prev_word;
            xf         = v ^ fcm_guess;
            xd         = v ^ dfcm_guess;
            pick_fcm   = top_zero_bits(xf) >= top_zero_bits(xd);
            r          = pick_fcm ? xf : xd;
            zb         = top_zero_bits(r) / 8;
            // Four zero bytes share the code of three, so eight zero bytes end up as seven.
            if (zb >= 4)
                zb--;
            nib = 4'(zb) | (pick_fcm ? 4'h0 : DFCM_FLAG);

            ctx_tab[ctx_idx] = v;
            ctx_idx          = 10'((64'(ctx_idx) << 6) ^ (v >> 48));
            d                = v - prev_word;
            dlt_tab[dlt_idx] = d;
            dlt_idx          = 10'((64'(dlt_idx) << 2) ^ (d >> 40));
            prev_word        = v;
            return r;
        endfunction

        function void push_byte(logic [7:0] b);
            comp_byte_t e;
            e.data       = b;
            e.run_end    = 1'b0;
            e.stream_end = 1'b0;
            coming_bytes.insert(coming_bytes.size(), e);
        endfunction

        function void push_residual(logic [63:0] r, logic [3:0] nib);
            int cnt;
            cnt = (nib[2:0] > 3'd3) ? 7 - int'(nib[2:0]) : 8 - int'(nib[2:0]);
            for (int i = 0; i < cnt; i++)
                push_byte(r[8*i +: 8]);
        endfunction

        function void note_value(logic [63:0] v, logic fin);
            logic [3:0]  nib;
            logic [63:0] r;
            comp_byte_t  last;
            r = code_value(v, nib);
            if (!half_held)
            begin
                if (!fin)
                begin
                    held_nib  = nib;
                    held_res  = r;
                    half_held = 1'b1;
                    return;
                end
                // A final value that opens a pair goes out alone with a padding nibble.
                push_byte({nib, PAD_NIBBLE});
                push_residual(r, nib);
            end
            else
            begin
                push_byte({held_nib, nib});
                push_residual(held_res, held_nib);
                push_residual(r, nib);
                half_held = 1'b0;
                held_nib  = '0;
                held_res  = '0;
            end
            last            = coming_bytes.pop_back();
            last.run_end    = 1'b1;
            last.stream_end = fin;
            coming_bytes.insert(coming_bytes.size(), last);
        endfunction

        function void check_byte(logic [7:0] b, logic re, logic se);
            comp_byte_t e;
            if (coming_bytes.size() == 0)
            begin
                report($sformatf("byte %02h arrived with nothing outstanding", b));
            end
            else
            begin
                e = coming_bytes.pop_front();
                if (b !== e.data)
                    report($sformatf("out_byte %02h, predicted %02h", b, e.data));
                if (re !== e.run_end)
                    report($sformatf("run_end %b, predicted %b", re, e.run_end));
                if (se !== e.stream_end)
                    report($sformatf("stream_end %b, predicted %b", se, e.stream_end));
            end
            bytes_seen++;
        endfunction
    endclass

    logic clk;
    logic rst_n;

    fcd_in_if  in_ch();
    fcd_out_if out_ch();

    fcm_dfcm_float_compressor u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    compressed_stream_sb sb;

    logic tx_gaps;
    logic rx_gaps;
    logic quiet;
    logic want_long_hold;

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    initial
    begin
        #1000000;
        $display("*** FAILED ***");
        $finish;
    end

    // Offers one value, optionally after a short gap, and returns on the edge that takes it.
    task automatic send_value(input logic [63:0] v, input logic fin);
        if (tx_gaps && !quiet && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.value       <= v;
        in_ch.final_value <= fin;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_value(v, fin);
    endtask

    // Output side: checks each accepted byte and picks the next ready level.
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
                sb.check_byte(out_ch.out_byte, out_ch.run_end, out_ch.stream_end);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (want_long_hold)
            begin
                // Long stall so the internal queue fills and the input side backs up.
                want_long_hold = 1'b0;
                hold_left      = LONG_HOLD - 1;
                out_ch.ready <= 1'b0;
            end
            else if (rx_gaps && !quiet && $urandom_range(0, 4) == 0)
            begin
                hold_left = $urandom_range(1, 5) - 1;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        logic [63:0] v;
        logic [63:0] last_sent;
        logic [63:0] stride;
        logic [63:0] mask;
        logic [63:0] pool [8];
        logic        fin;
        int          mode;
        int          run_left;

        sb             = new();
        tx_gaps        = 1'b1;
        rx_gaps        = 1'b1;
        quiet          = 1'b0;
        want_long_hold = 1'b0;
        last_sent      = '0;
        stride         = 64'd1;
        mode           = 0;
        run_left       = 0;
        foreach (pool[i])
            pool[i] = {$urandom, $urandom};

        rst_n              = 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.value       <= '0;
        in_ch.final_value <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: zero residuals, extreme words, every zero-byte count, pairing corners.
        send_value(64'h0, 1'b0);
        send_value(64'h0, 1'b0);
        send_value(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_value(64'h8000_0000_0000_0000, 1'b0);
        send_value(64'h0000_0000_0000_0001, 1'b0);
        send_value(64'h0000_0000_0000_00FF, 1'b0);
        send_value(64'h0000_0000_8000_0000, 1'b0);
        send_value(64'h0000_0001_0000_0000, 1'b0);
        repeat (4) send_value(64'h3FF0_0000_0000_0000, 1'b0);
        for (int k = 0; k < 6; k++)
            send_value(64'h4000_0000_0000_0000 + 64'(k) * 64'h10, 1'b0);
        // Final value opening a pair, then one closing a pair, then another lone final.
        send_value(64'h3FF8_0000_0000_0000, 1'b1);
        send_value(64'hC009_21FB_5444_2D18, 1'b0);
        send_value(64'h0000_00FF_FFFF_FFFF, 1'b1);
        send_value(64'h7FEF_FFFF_FFFF_FFFF, 1'b1);

        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (run_left == 0)
            begin
                run_left = $urandom_range(2, 20);
                mode     = $urandom_range(0, 5);
                stride   = {($urandom_range(0, 3) == 0) ? $urandom : 32'h0, $urandom}
                           >> $urandom_range(0, 60);
                tx_gaps  = $urandom_range(0, 2) != 0;
                rx_gaps  = $urandom_range(0, 2) != 0;
            end
            case (mode)
                0: v = {$urandom, $urandom};
                1: v = last_sent;
                2: v = last_sent + stride;
                3:
                begin
                    mask = {64{1'b1}} >> (8 * $urandom_range(0, 7));
                    v    = last_sent ^ ({$urandom, $urandom} & mask);
                end
                4: v = {$urandom, $urandom} >> (8 * $urandom_range(1, 8));
                default: v = pool[$urandom_range(0, 7)];
            endcase
            fin = (k == RANDOM_ITEMS - 1) || ($urandom_range(0, 11) == 0);
            run_left--;
            quiet = (k >= RANDOM_ITEMS - 50);
            if (k == 100)
                want_long_hold = 1'b1;
            send_value(v, fin);
            last_sent = v;
        end
        in_ch.valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (sb.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
